### hw/rtl/kov_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kov_pkg;

    localparam int KOV_KMER_LEN    = 8;
    localparam int KOV_COUNT_BITS  = 12;
    localparam int KOV_ADDR_BITS   = 16;
    localparam int KOV_HIT_BITS    = 12;
    localparam int KOV_TABLE_DEPTH = 1 << KOV_ADDR_BITS;

    // request operation codes
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_READ_BASE   = 1'b1;

    // ASCII base codes
    localparam logic [7:0] BASE_A = 8'h41;
    localparam logic [7:0] BASE_C = 8'h43;
    localparam logic [7:0] BASE_G = 8'h47;
    localparam logic [7:0] BASE_N = 8'h4E;
    localparam logic [7:0] BASE_T = 8'h54;

    typedef logic [KOV_ADDR_BITS-1:0] t_addr;
    typedef logic [KOV_HIT_BITS-1:0]  t_hits;

    typedef struct packed {
        logic       operation;
        t_addr      table_address;
        logic       table_bit;
        logic [7:0] base_byte;
        logic       last_base;
    } t_kov_req;

    typedef struct packed {
        logic  flip;
        t_hits read_hits;
        t_hits revcomp_hits;
    } t_kov_res;

    // base in flight toward the tally stage, aligned with the table read data
    typedef struct packed {
        logic valid;
        logic count_fwd;
        logic count_rc;
        logic last;
    } t_kov_probe;

endpackage

`default_nettype wire

### hw/rtl/kov_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kov_in_if
    import kov_pkg::*;
();
    logic     valid;
    logic     ready;
    t_kov_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/kov_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface kov_out_if
    import kov_pkg::*;
();
    logic     valid;
    logic     ready;
    t_kov_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/kov_member_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module kov_member_mem
    import kov_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_wr_en,
    input  wire t_addr i_wr_addr,
    input  wire logic  i_wr_bit,
    input  wire logic  i_rd_en,
    input  wire t_addr i_rd_addr_fwd,
    input  wire t_addr i_rd_addr_rc,
    output logic       o_rd_fwd,
    output logic       o_rd_rc
);

    logic mem [KOV_TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_bit;
        end
    end

    // hold read data while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_fwd <= mem[i_rd_addr_fwd];
            o_rd_rc  <= mem[i_rd_addr_rc];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/kov_kmer_front.sv
`timescale 1ns / 1ps
`default_nettype none

module kov_kmer_front
    import kov_pkg::*;
#(
    parameter int KMER_LEN = KOV_KMER_LEN
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_advance,
    kov_in_if.sink      i_req,
    output logic        o_wr_en,
    output t_addr       o_wr_addr,
    output logic        o_wr_bit,
    output t_addr       o_rd_addr_fwd,
    output t_addr       o_rd_addr_rc,
    output t_kov_probe  o_probe
);

    localparam int KMER_BITS = 2 * KMER_LEN;
    localparam int RUN_BITS  = $clog2(KMER_LEN + 1);
    localparam logic [RUN_BITS-1:0] RUN_FULL = RUN_BITS'(KMER_LEN);

    logic [KMER_BITS-1:0] r_fwd_kmer, n_fwd_kmer, shift_fwd;
    logic [KMER_BITS-1:0] r_rc_kmer,  n_rc_kmer,  shift_rc;
    logic [RUN_BITS-1:0]  r_valid_run, n_valid_run;
    logic [RUN_BITS-1:0]  r_pos_seen,  n_pos_seen;
    t_kov_probe           r_probe,     n_probe;
    logic [1:0]           fwd_code, rc_code;
    logic                 is_n;
    logic                 accept;
    logic                 base_acc;
    logic                 full;

    assign i_req.ready = i_advance;
    assign accept      = i_req.valid && i_advance;
    assign base_acc    = accept && (i_req.data.operation == OP_READ_BASE);

    always_comb begin
        fwd_code = 2'd0;
        rc_code  = 2'd0;
        is_n     = 1'b0;
        unique case (i_req.data.base_byte)
            BASE_A: begin fwd_code = 2'd0; rc_code = 2'd3; end
            BASE_C: begin fwd_code = 2'd1; rc_code = 2'd2; end
            BASE_G: begin fwd_code = 2'd2; rc_code = 2'd1; end
            BASE_T: begin fwd_code = 2'd3; rc_code = 2'd0; end
            BASE_N: is_n = 1'b1;
            default: begin fwd_code = 2'd0; rc_code = 2'd0; end
        endcase
    end

    always_comb begin
        shift_fwd = {r_fwd_kmer[KMER_BITS-3:0], fwd_code};
        shift_rc  = {rc_code, r_rc_kmer[KMER_BITS-1:2]};

        if (is_n) begin
            n_fwd_kmer  = '0;
            n_rc_kmer   = '0;
            n_valid_run = '0;
        end else begin
            n_fwd_kmer  = shift_fwd;
            n_rc_kmer   = shift_rc;
            n_valid_run = (r_valid_run == RUN_FULL) ? r_valid_run : r_valid_run + 1'b1;
        end
        full = (n_valid_run == RUN_FULL);

        n_probe.valid     = base_acc;
        n_probe.count_fwd = full && !i_req.data.last_base;
        n_probe.count_rc  = full && (r_pos_seen == RUN_FULL);
        n_probe.last      = i_req.data.last_base;

        n_pos_seen = (r_pos_seen == RUN_FULL) ? r_pos_seen : r_pos_seen + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_kmer  <= '0;
            r_rc_kmer   <= '0;
            r_valid_run <= '0;
            r_pos_seen  <= '0;
            r_probe     <= '0;
        end else if (i_advance) begin
            r_probe <= n_probe;
            if (base_acc) begin
                // restart the window at the end of every read
                if (i_req.data.last_base) begin
                    r_fwd_kmer  <= '0;
                    r_rc_kmer   <= '0;
                    r_valid_run <= '0;
                    r_pos_seen  <= '0;
                end else begin
                    r_fwd_kmer  <= n_fwd_kmer;
                    r_rc_kmer   <= n_rc_kmer;
                    r_valid_run <= n_valid_run;
                    r_pos_seen  <= n_pos_seen;
                end
            end
        end
    end

    assign o_wr_en       = accept && (i_req.data.operation == OP_TABLE_WRITE);
    assign o_wr_addr     = i_req.data.table_address;
    assign o_wr_bit      = i_req.data.table_bit;
    assign o_rd_addr_fwd = t_addr'(n_fwd_kmer);
    assign o_rd_addr_rc  = t_addr'(n_rc_kmer);
    assign o_probe       = r_probe;

endmodule

`default_nettype wire

### hw/rtl/kov_tally.sv
`timescale 1ns / 1ps
`default_nettype none

module kov_tally
    import kov_pkg::*;
#(
    parameter int COUNT_BITS = KOV_COUNT_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_kov_probe i_probe,
    input  wire logic       i_hit_fwd,
    input  wire logic       i_hit_rc,
    output logic            o_advance,
    kov_out_if.source       o_res
);

    logic [COUNT_BITS-1:0] r_fwd_count, n_fwd_count;
    logic [COUNT_BITS-1:0] r_rc_count,  n_rc_count;
    logic                  r_out_valid;
    t_kov_res              r_out_data, n_out_data;
    logic                  emit;

    // freeze the whole pipeline while a result waits on a stalled sink
    assign o_advance = !r_out_valid || o_res.ready;
    assign emit      = i_probe.valid && i_probe.last;

    always_comb begin
        n_fwd_count = r_fwd_count;
        n_rc_count  = r_rc_count;
        if (i_probe.valid && i_probe.count_fwd && i_hit_fwd && (r_fwd_count != '1)) begin
            n_fwd_count = r_fwd_count + 1'b1;
        end
        if (i_probe.valid && i_probe.count_rc && i_hit_rc && (r_rc_count != '1)) begin
            n_rc_count = r_rc_count + 1'b1;
        end
        n_out_data.flip         = (n_fwd_count > n_rc_count);
        n_out_data.read_hits    = t_hits'(n_fwd_count);
        n_out_data.revcomp_hits = t_hits'(n_rc_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_count <= '0;
            r_rc_count  <= '0;
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= emit;
            if (emit) begin
                r_fwd_count <= '0;
                r_rc_count  <= '0;
            end else begin
                r_fwd_count <= n_fwd_count;
                r_rc_count  <= n_rc_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;

endmodule

`default_nettype wire

### hw/rtl/kmer_orientation_vote.sv
// Channel   Dir  Modport       Payload
// i_req     in   kov_in_if     operation, table_address, table_bit, base_byte, last_base
// o_res     out  kov_out_if    flip, read_hits, revcomp_hits
//
// One request per cycle unless a result stalls: table writes and bases alike. A base
// shifts the k-mer pair and looks both codes up in the 64K x 1 membership memory (two read
// ports); the read data and the probe register feed the tally, which counts the hits, and a
// last base loads the result register. Reset clears the window and the counts, not the
// membership memory. While a result waits on a stalled sink, the whole pipeline holds and
// i_req.ready is low.
`timescale 1ns / 1ps
`default_nettype none

module kmer_orientation_vote
    import kov_pkg::*;
#(
    parameter int KMER_LEN   = KOV_KMER_LEN,
    parameter int COUNT_BITS = KOV_COUNT_BITS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kov_in_if.sink    i_req,
    kov_out_if.source o_res
);

    logic       advance;
    logic       wr_en;
    t_addr      wr_addr;
    logic       wr_bit;
    t_addr      rd_addr_fwd;
    t_addr      rd_addr_rc;
    logic       hit_fwd;
    logic       hit_rc;
    t_kov_probe probe;

    kov_kmer_front #(
        .KMER_LEN (KMER_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_req         (i_req),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_bit      (wr_bit),
        .o_rd_addr_fwd (rd_addr_fwd),
        .o_rd_addr_rc  (rd_addr_rc),
        .o_probe       (probe)
    );

    kov_member_mem u_mem (
        .i_clk         (i_clk),
        .i_wr_en       (wr_en),
        .i_wr_addr     (wr_addr),
        .i_wr_bit      (wr_bit),
        .i_rd_en       (advance),
        .i_rd_addr_fwd (rd_addr_fwd),
        .i_rd_addr_rc  (rd_addr_rc),
        .o_rd_fwd      (hit_fwd),
        .o_rd_rc       (hit_rc)
    );

    kov_tally #(
        .COUNT_BITS (COUNT_BITS)
    ) u_tally (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_probe   (probe),
        .i_hit_fwd (hit_fwd),
        .i_hit_rc  (hit_rc),
        .o_advance (advance),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire

### dv/kmer_orientation_vote_tb.sv
`timescale 1ns / 1ps

module kmer_orientation_vote_tb;
    import kov_pkg::*;

    localparam int KMER_BITS = 2 * KOV_KMER_LEN;
    localparam int N_ROWS    = 21;
    localparam int N_RANDOM  = 1000;
    localparam int CALM_TAIL = 150;

    typedef struct packed {
        logic       op;
        t_addr      addr;
        logic       tbit;
        logic [7:0] base;
        logic       last;
        int         reps;
        bit         chk;
        logic       flip;
        t_hits      rd;
        t_hits      rc;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    kov_in_if  req_if ();
    kov_out_if res_if ();

    kmer_orientation_vote dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // predictor state
    bit                   member_bits  [KOV_TABLE_DEPTH];
    bit                   member_known [KOV_TABLE_DEPTH];
    logic [KMER_BITS-1:0] fwd_kmer;
    logic [KMER_BITS-1:0] rc_kmer;
    int                   win_run;
    int                   bases_seen;
    t_hits                fwd_hits;
    t_hits                rc_hits;

    t_kov_res pending_votes [$];
    int       fails;
    int       sent;
    bit       src_idle;
    bit       snk_idle;

    // homopolymer reads probe the all-A and all-T codes
    t_stim_row dir_rows [N_ROWS] = '{
        '{OP_TABLE_WRITE, 16'h0000, 1'b1, 8'hFF,  1'b1, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_TABLE_WRITE, 16'hFFFF, 1'b1, BASE_N, 1'b1, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'hFFFF, 1'b1, BASE_A, 1'b1, 40,   1'b1, 1'b0, 12'd32,  12'd32},
        '{OP_TABLE_WRITE, 16'hFFFF, 1'b0, 8'h00,  1'b0, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h0000, 1'b0, BASE_A, 1'b1, 40,   1'b1, 1'b1, 12'd32,  12'd0},
        '{OP_READ_BASE,   16'hA5A5, 1'b1, BASE_A, 1'b1, 7,    1'b1, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h5A5A, 1'b0, BASE_A, 1'b1, 8,    1'b1, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'hFFFF, 1'b1, BASE_A, 1'b1, 9,    1'b1, 1'b1, 12'd1,   12'd0},
        '{OP_TABLE_WRITE, 16'hFFFF, 1'b1, BASE_T, 1'b0, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h0000, 1'b0, BASE_A, 1'b1, 9,    1'b1, 1'b0, 12'd1,   12'd1},
        '{OP_READ_BASE,   16'h1234, 1'b1, BASE_A, 1'b0, 8,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h4321, 1'b0, BASE_N, 1'b0, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h8001, 1'b1, BASE_C, 1'b1, 9,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h7FFE, 1'b0, BASE_T, 1'b0, 10,   1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'hFFFF, 1'b1, BASE_N, 1'b1, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h0F0F, 1'b0, 8'h00,  1'b0, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'hF0F0, 1'b1, 8'hFF,  1'b0, 1,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h3C3C, 1'b0, 8'h60,  1'b0, 3,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'hC3C3, 1'b1, BASE_G, 1'b0, 6,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h6666, 1'b0, 8'h61,  1'b0, 2,    1'b0, 1'b0, 12'd0,   12'd0},
        '{OP_READ_BASE,   16'h9999, 1'b1, BASE_T, 1'b1, 1,    1'b0, 1'b0, 12'd0,   12'd0}
    };

    function automatic void queue_vote(input t_kov_res v);
        pending_votes.insert(pending_votes.size(), v);
    endfunction

    // Advance the vote state by one request; return 1 when it closes a read.
    function automatic bit vote_step(input t_kov_req r, output t_kov_res res);
        logic [1:0] fcode;
        logic [1:0] ccode;
        bit         full;
        res = '0;
        if (r.operation == OP_TABLE_WRITE) begin
            member_bits[r.table_address]  = r.table_bit;
            member_known[r.table_address] = 1'b1;
            return 1'b0;
        end
        if (r.base_byte == BASE_N) begin
            fwd_kmer = '0;
            rc_kmer  = '0;
            win_run  = 0;
        end else begin
            case (r.base_byte)
                BASE_A: begin fcode = 2'd0; ccode = 2'd3; end
                BASE_C: begin fcode = 2'd1; ccode = 2'd2; end
                BASE_G: begin fcode = 2'd2; ccode = 2'd1; end
                BASE_T: begin fcode = 2'd3; ccode = 2'd0; end
                default: begin fcode = 2'd0; ccode = 2'd0; end
            endcase
            fwd_kmer = {fwd_kmer[KMER_BITS-3:0], fcode};
            rc_kmer  = {ccode, rc_kmer[KMER_BITS-1:2]};
            if (win_run < KOV_KMER_LEN)
                win_run++;
        end
        full = (win_run >= KOV_KMER_LEN);
        if (full && !r.last_base && member_bits[fwd_kmer[KOV_ADDR_BITS-1:0]] && fwd_hits != '1)
            fwd_hits++;
        if (full && bases_seen >= KOV_KMER_LEN && member_bits[rc_kmer[KOV_ADDR_BITS-1:0]]
                && rc_hits != '1)
            rc_hits++;
        if (bases_seen < KOV_KMER_LEN)
            bases_seen++;
        if (!r.last_base)
            return 1'b0;
        res.flip         = (fwd_hits > rc_hits);
        res.read_hits    = fwd_hits;
        res.revcomp_hits = rc_hits;
        fwd_kmer   = '0;
        rc_kmer    = '0;
        win_run    = 0;
        bases_seen = 0;
        fwd_hits   = '0;
        rc_hits    = '0;
        return 1'b1;
    endfunction

    // Return 1 when the window is full after this base; give the codes it will look up.
    function automatic bit peek_full(input t_kov_req r, output t_addr fa, output t_addr ca);
        logic [1:0]           fcode;
        logic [1:0]           ccode;
        logic [KMER_BITS-1:0] nf;
        logic [KMER_BITS-1:0] nc;
        fa = '0;
        ca = '0;
        if (r.operation == OP_TABLE_WRITE || r.base_byte == BASE_N)
            return 1'b0;
        case (r.base_byte)
            BASE_A: begin fcode = 2'd0; ccode = 2'd3; end
            BASE_C: begin fcode = 2'd1; ccode = 2'd2; end
            BASE_G: begin fcode = 2'd2; ccode = 2'd1; end
            BASE_T: begin fcode = 2'd3; ccode = 2'd0; end
            default: begin fcode = 2'd0; ccode = 2'd0; end
        endcase
        nf = {fwd_kmer[KMER_BITS-3:0], fcode};
        nc = {ccode, rc_kmer[KMER_BITS-1:2]};
        fa = nf[KOV_ADDR_BITS-1:0];
        ca = nc[KOV_ADDR_BITS-1:0];
        return (win_run + 1 >= KOV_KMER_LEN);
    endfunction

    // Drive one request from a falling edge and hold it until accepted.
    task automatic send(input t_kov_req r, input bit typed, input t_kov_res typed_res);
        t_kov_res res;
        bit       closes;
        if (src_idle && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            req_if.data  <= t_kov_req'($urandom);
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        closes = vote_step(r, res);
        if (closes)
            queue_vote(typed ? typed_res : res);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_fill(input t_addr a);
        t_kov_req w;
        w               = t_kov_req'($urandom);
        w.operation     = OP_TABLE_WRITE;
        w.table_address = a;
        w.table_bit     = 1'($urandom_range(0, 1));
        send(w, 1'b0, '0);
    endtask

    // Write any entry the base will look up first, so no lookup lands on an unwritten entry.
    task automatic send_base(input t_kov_req r, input bit typed, input t_kov_res typed_res);
        t_addr fa;
        t_addr ca;
        if (peek_full(r, fa, ca)) begin
            if (!member_known[fa])
                send_fill(fa);
            if (!member_known[ca])
                send_fill(ca);
        end
        send(r, typed, typed_res);
    endtask

    task automatic send_random_write();
        send_fill(t_addr'($urandom_range(0, KOV_TABLE_DEPTH - 1)));
    endtask

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Sink side: accept by default, stall in random bursts when enabled.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (snk_idle && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : res_check
        t_kov_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_votes.size() == 0) begin
                $error("unexpected result: flip %0d read_hits %0d revcomp_hits %0d",
                       res_if.data.flip, res_if.data.read_hits, res_if.data.revcomp_hits);
                fails++;
            end else begin
                want = pending_votes.pop_front();
                if (res_if.data.flip !== want.flip) begin
                    $error("flip: expected %0d, actual %0d", want.flip, res_if.data.flip);
                    fails++;
                end
                if (res_if.data.read_hits !== want.read_hits) begin
                    $error("read_hits: expected %0d, actual %0d",
                           want.read_hits, res_if.data.read_hits);
                    fails++;
                end
                if (res_if.data.revcomp_hits !== want.revcomp_hits) begin
                    $error("revcomp_hits: expected %0d, actual %0d",
                           want.revcomp_hits, res_if.data.revcomp_hits);
                    fails++;
                end
            end
        end
    end

    initial begin
        #(10_000_000);
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_kov_req   r;
        t_kov_res   tr;
        int         len;
        int         pick;
        bit         paused;
        logic [7:0] acgt [4];

        acgt       = '{BASE_A, BASE_C, BASE_G, BASE_T};
        fails      = 0;
        sent       = 0;
        paused     = 1'b0;
        src_idle   = 1'b0;
        snk_idle   = 1'b0;
        fwd_kmer   = '0;
        rc_kmer    = '0;
        win_run    = 0;
        bases_seen = 0;
        fwd_hits   = '0;
        rc_hits    = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle = 1'b1;
        snk_idle = 1'b1;
        for (int i = 0; i < N_ROWS; i++) begin
            for (int k = 0; k < dir_rows[i].reps; k++) begin
                r.operation     = dir_rows[i].op;
                r.table_address = dir_rows[i].addr;
                r.table_bit     = dir_rows[i].tbit;
                r.base_byte     = dir_rows[i].base;
                r.last_base     = dir_rows[i].last && (k == dir_rows[i].reps - 1);
                tr.flip         = dir_rows[i].flip;
                tr.read_hits    = dir_rows[i].rd;
                tr.revcomp_hits = dir_rows[i].rc;
                if (r.operation == OP_READ_BASE)
                    send_base(r, dir_rows[i].chk, tr);
                else
                    send(r, dir_rows[i].chk, tr);
            end
        end

        sent = 0;
        while (sent < N_RANDOM) begin
            if (N_RANDOM - sent < CALM_TAIL) begin
                src_idle = 1'b0;
                snk_idle = 1'b0;
            end else begin
                src_idle = ($urandom_range(0, 3) != 0);
                snk_idle = ($urandom_range(0, 3) != 0);
            end
            len = ($urandom_range(0, 24) == 0) ? $urandom_range(31, 200) : $urandom_range(1, 30);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_random_write();
                pick            = $urandom_range(0, 19);
                r               = t_kov_req'($urandom);
                r.operation     = OP_READ_BASE;
                if (pick < 15)
                    r.base_byte = acgt[2'($urandom_range(0, 3))];
                else if (pick < 17)
                    r.base_byte = BASE_N;
                else
                    r.base_byte = 8'($urandom_range(0, 255));
                r.last_base     = (k == len - 1);
                send_base(r, 1'b0, '0);
            end
            // hold the sender once until the result side has drained
            if (!paused && sent >= N_RANDOM / 2) begin
                paused = 1'b1;
                req_if.valid <= 1'b0;
                @(negedge i_clk);
                while (pending_votes.size() != 0)
                    @(negedge i_clk);
            end
        end

        req_if.valid <= 1'b0;
        while (pending_votes.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/kov_pkg.sv
hw/rtl/kov_in_if.sv
hw/rtl/kov_out_if.sv
hw/rtl/kov_member_mem.sv
hw/rtl/kov_kmer_front.sv
hw/rtl/kov_tally.sv
hw/rtl/kmer_orientation_vote.sv
dv/kmer_orientation_vote_tb.sv
